/* hdl/ddlp_pkg.sv */
// ----------------------------------------------------------------------------
// ddlp_pkg
// Shared types, constants and helper functions of the decimal list parser.
// ----------------------------------------------------------------------------
package ddlp_pkg;

  // Largest number of values produced for one list.
  localparam int unsigned MAX_VALUES = 16;
  localparam int unsigned CNT_W      = $clog2(MAX_VALUES + 1);
  localparam int unsigned POS_W      = 4;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W     = 2;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SEPARATOR = CFG_ADDR_W'(0);
  localparam logic [7:0]            SEP_RESET      = 8'd44;

  // Queue depths (powers of two, so the pointers wrap on their own).
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

  // Magnitude saturates at 2^31; a positive value saturates at 2^31 - 1.
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_list;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  field_value;
    logic [POS_W-1:0]    field_position;
    logic                list_done;
  } out_item_t;

  typedef enum logic [2:0] {
    CLS_SPACE    = 3'd0,
    CLS_PLUS     = 3'd1,
    CLS_MINUS    = 3'd2,
    CLS_DIGIT    = 3'd3,
    CLS_OTHER    = 3'd4
  } char_class_t;

  // One classified byte, handed from the front end to the back end.
  typedef struct packed {
    logic        is_sep;
    logic        end_of_list;
    char_class_t cls;
    logic [3:0]  digit;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'b001,
    PH_DIGITS = 3'b010,
    PH_STOP   = 3'b100
  } phase_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t cls;
    cls = CLS_OTHER;
    if (c == 8'd32 || c inside {[8'd9:8'd13]}) begin
      cls = CLS_SPACE;
    end else if (c == 8'd43) begin
      cls = CLS_PLUS;
    end else if (c == 8'd45) begin
      cls = CLS_MINUS;
    end else if (c inside {[8'd48:8'd57]}) begin
      cls = CLS_DIGIT;
    end
    return cls;
  endfunction

  // Signed result of a field from its saturated magnitude and sign.
  function automatic logic [31:0] field_result(input logic [31:0] mag, input logic neg);
    logic [31:0] v;
    if (neg) begin
      v = 32'd0 - mag;
    end else begin
      v = (mag > INT_MAX) ? INT_MAX : mag;
    end
    return v;
  endfunction

endpackage

/* hdl/ddlp_front.sv */
// ----------------------------------------------------------------------------
// ddlp_front
// Accepts list bytes, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module ddlp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        sep_char,
  input  logic              in_push,
  input  ddlp_pkg::in_item_t in_data,
  output logic              in_full,
  output logic              cmd_valid,
  output ddlp_pkg::cmd_t    cmd_head,
  input  logic              cmd_pop
);
  import ddlp_pkg::*;

  cmd_t                  q_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_PTR_W:0]   cnt_r, cnt_nxt;
  logic                  do_push;
  cmd_t                  cmd_new;

  assign in_full   = (cnt_r == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd_head  = q_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;

  always_comb begin
    cmd_new.is_sep      = (in_data.text_byte == sep_char);
    cmd_new.end_of_list = in_data.end_of_list;
    cmd_new.cls         = classify(in_data.text_byte);
    cmd_new.digit       = in_data.text_byte[3:0];
  end

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (CMDQ_PTR_W+1)'(do_push) - (CMDQ_PTR_W+1)'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cmd_new;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (CMDQ_PTR_W+1)'(CMDQ_DEPTH))
    else $error("command queue count beyond its depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !cmd_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("command queue count lost a transfer");

endmodule

/* hdl/ddlp_back.sv */
// ----------------------------------------------------------------------------
// ddlp_back
// Runs the field parser on classified bytes and produces the field values.
// ----------------------------------------------------------------------------
module ddlp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  ddlp_pkg::cmd_t     cmd_head,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output ddlp_pkg::out_item_t res_item
);
  import ddlp_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  phase_t           phase_r, phase_nxt;
  logic             full_r, full_nxt;
  logic             pend_r, pend_nxt;

  logic             need_emit;
  logic [CNT_W-1:0] count_inc;
  logic             reach_max;
  logic [35:0]      mag_wide;
  logic [31:0]      mag_dig;
  logic [31:0]      mag_p;
  logic             neg_p;
  phase_t           phase_p;

  assign need_emit = !full_r && (cmd_head.is_sep || cmd_head.end_of_list);
  assign count_inc = count_r + 1'b1;
  assign reach_max = (count_inc >= CNT_W'(MAX_VALUES));

  // Times ten as two shifted copies, plus the new digit, saturated at 2^31.
  assign mag_wide = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1) + 36'(cmd_head.digit);
  assign mag_dig  = (mag_wide > 36'(MAG_LIMIT)) ? MAG_LIMIT : mag_wide[31:0];

  // Field state after a byte that is not a separator.
  always_comb begin
    mag_p   = mag_r;
    neg_p   = neg_r;
    phase_p = phase_r;
    case (phase_r)
      PH_SPACE: begin
        case (cmd_head.cls)
          CLS_SPACE: ;
          CLS_PLUS:  phase_p = PH_DIGITS;
          CLS_MINUS: begin
            neg_p   = 1'b1;
            phase_p = PH_DIGITS;
          end
          CLS_DIGIT: begin
            mag_p   = mag_dig;
            phase_p = PH_DIGITS;
          end
          default:   phase_p = PH_STOP;
        endcase
      end
      PH_DIGITS: begin
        if (cmd_head.cls == CLS_DIGIT) begin
          mag_p = mag_dig;
        end else begin
          phase_p = PH_STOP;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    phase_nxt = phase_r;
    full_nxt  = full_r;
    pend_nxt  = pend_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res_item.field_value    = field_result(mag_r, neg_r);
    res_item.field_position = POS_W'(count_r);
    res_item.list_done      = 1'b1;

    if (pend_r) begin
      // Empty final field after a separator that ended the list.
      if (!res_full) begin
        res_push                = 1'b1;
        res_item.field_value    = '0;
        pend_nxt                = 1'b0;
        count_nxt               = '0;
        mag_nxt                 = '0;
        neg_nxt                 = 1'b0;
        phase_nxt               = PH_SPACE;
        full_nxt                = 1'b0;
      end
    end else if (cmd_valid && (!need_emit || !res_full)) begin
      cmd_pop = 1'b1;
      if (full_r) begin
        if (cmd_head.end_of_list) begin
          count_nxt = '0;
          full_nxt  = 1'b0;
        end
      end else if (cmd_head.is_sep) begin
        res_push           = 1'b1;
        res_item.list_done = reach_max;
        count_nxt          = count_inc;
        mag_nxt            = '0;
        neg_nxt            = 1'b0;
        phase_nxt          = PH_SPACE;
        full_nxt           = reach_max;
        if (cmd_head.end_of_list) begin
          if (reach_max) begin
            count_nxt = '0;
            full_nxt  = 1'b0;
          end else begin
            pend_nxt = 1'b1;
          end
        end
      end else if (cmd_head.end_of_list) begin
        res_push             = 1'b1;
        res_item.field_value = field_result(mag_p, neg_p);
        count_nxt            = '0;
        mag_nxt              = '0;
        neg_nxt              = 1'b0;
        phase_nxt            = PH_SPACE;
      end else begin
        mag_nxt   = mag_p;
        neg_nxt   = neg_p;
        phase_nxt = phase_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mag_r   <= '0;
      neg_r   <= 1'b0;
      phase_r <= PH_SPACE;
      full_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      phase_r <= phase_nxt;
      full_r  <= full_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !cmd_pop)
    else $error("command taken while the final empty field is pending");

  assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written into a full result queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (count_r == CNT_W'(MAX_VALUES)))
    else $error("list marked full below the value limit");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd_head.end_of_list && !pend_nxt) |=> (count_r == '0 && !full_r))
    else $error("list state not cleared after the last byte");

endmodule

/* hdl/ddlp_outq.sv */
// ----------------------------------------------------------------------------
// ddlp_outq
// Result queue that holds field values until the consumer takes them.
// ----------------------------------------------------------------------------
module ddlp_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  ddlp_pkg::out_item_t res_item,
  output logic                res_full,
  output logic                out_empty,
  output ddlp_pkg::out_item_t out_data,
  input  logic                out_pop
);
  import ddlp_pkg::*;

  out_item_t             q_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUTQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUTQ_PTR_W:0]   cnt_r, cnt_nxt;
  logic                  do_pop;

  assign res_full  = (cnt_r == (OUTQ_PTR_W+1)'(OUTQ_DEPTH));
  assign out_empty = (cnt_r == '0);
  assign out_data  = q_r[rd_ptr_r];
  assign do_pop    = out_pop && !out_empty;

  always_comb begin
    wr_ptr_nxt = res_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (OUTQ_PTR_W+1)'(res_push) - (OUTQ_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      q_r[wr_ptr_r] <= res_item;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (OUTQ_PTR_W+1)'(OUTQ_DEPTH))
    else $error("result queue count beyond its depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    (!res_push && do_pop) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("result queue count lost a transfer");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_empty && !res_push) |=> out_empty)
    else $error("result queue filled without a write");

endmodule

/* hdl/delimited_decimal_list_parser_unit.sv */
// ----------------------------------------------------------------------------
// delimited_decimal_list_parser_unit
// Splits a byte stream into separator-delimited fields and converts each
// field to a saturated signed 32-bit integer by atoi rules.
// ----------------------------------------------------------------------------
// The byte that closes a field is written into the command queue; the parser
// takes it from there and writes the result into the result queue, from
// which it shows on the output ports. Throughput: one byte per cycle while
// the queues have room and no empty final field is pending; a separator that
// ends a list below the value limit emits two values before the next byte.
// Reset: synchronous, active low; it empties both queues, clears the parse
// state and sets the separator register to 44 (a comma).
// ----------------------------------------------------------------------------
module delimited_decimal_list_parser_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_push,
  input  ddlp_pkg::in_item_t                  in_data,
  output logic                                in_full,
  // Result channel.
  output logic                                out_empty,
  output ddlp_pkg::out_item_t                 out_data,
  input  logic                                out_pop,
  // Configuration port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ddlp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [ddlp_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ddlp_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import ddlp_pkg::*;

  // The configuration port has a single register: the separator byte. It
  // is written in the access phase of a write transfer and never stalls.
  logic [7:0] sep_r, sep_nxt;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    sep_nxt = sep_r;
    if (cfg_wr && (cfg_paddr == ADDR_SEPARATOR)) begin
      sep_nxt = cfg_pwdata[7:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == ADDR_SEPARATOR) begin
      cfg_prdata = CFG_DATA_W'(sep_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
    end else begin
      sep_r <= sep_nxt;
    end
  end

  // The front end tags each byte as separator, whitespace, sign, digit or
  // other and queues it. The separator comparison is done here, so the parser
  // only sees a separator flag, a class, a digit value and the end-of-list flag.
  logic      cmd_valid;
  cmd_t      cmd_head;
  logic      cmd_pop;

  ddlp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .sep_char  (sep_r),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop)
  );

  // The back end owns the per-list state: value count, magnitude, sign and
  // field phase. It consumes one queued byte per cycle, and stalls only when
  // the byte would emit a value and the result queue has no room, or while a final empty field is pending.
  logic      res_push;
  logic      res_full;
  out_item_t res_item;

  ddlp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  // Results wait here, so the parser keeps running while the consumer
  // holds off its pops, until the four entries of the queue are full.
  ddlp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_data  (out_data),
    .out_pop   (out_pop)
  );

endmodule
